### sv/idalloc_pkg.sv
// ----------------------------------------------------------------------------
// idalloc_pkg
// Shared constants, codes and types for the ID allocator with reuse delay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idalloc_pkg;

  localparam int MAX_IDS  = 1024;
  localparam int TIME_W   = 48;
  localparam int ID_W     = $clog2(MAX_IDS);
  localparam int CNT_W    = $clog2(MAX_IDS + 1);
  localparam int LIMIT_W  = 11;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  // request codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

  typedef struct packed {
    logic rd_en;   // fetch head entry
    logic pop;
    logic push;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

`default_nettype wire

### sv/id_allocator_with_cooldown.sv
// ----------------------------------------------------------------------------
// id_allocator_with_cooldown
// Allocates IDs from a fresh counter or from a queue of released IDs once
// their reuse delay has run out; handles release and check requests.
//
//   channel  direction  payload
//   in_      input      op, id, now
//   out_     output     result_id, status
//   cfg_     input      index, data (0 id_limit, 1 cooldown)
//
// The transfer edge starts the bitmap and queue RAM reads; the edge that
// finishes the request writes back and loads the output register.
// One request is in flight at a time; the next is taken the cycle after.
// A stalled output holds the request back from finishing.
// Synchronous reset; the bitmap needs no clearing pass, entries at or above
// the fresh count are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module id_allocator_with_cooldown (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [idalloc_pkg::OP_W-1:0]         in_op,
  input  wire logic [idalloc_pkg::ID_W-1:0]         in_id,
  input  wire logic [idalloc_pkg::TIME_W-1:0]       in_now,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [idalloc_pkg::ID_W-1:0]         out_result_id,
  output logic      [idalloc_pkg::STATUS_W-1:0]     out_status,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [idalloc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [idalloc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [idalloc_pkg::CNT_W-1:0] MAX_CNT =
    idalloc_pkg::CNT_W'(idalloc_pkg::MAX_IDS);

  logic [idalloc_pkg::LIMIT_W-1:0]  id_limit_r;
  logic [idalloc_pkg::TIME_W-1:0]   cooldown_r;
  logic [idalloc_pkg::CNT_W-1:0]    fresh_r, fresh_nxt;
  logic                             busy_r;
  logic [idalloc_pkg::OP_W-1:0]     op_r;
  logic [idalloc_pkg::ID_W-1:0]     id_r;
  logic [idalloc_pkg::TIME_W-1:0]   now_r;
  logic                             out_valid_r;
  logic [idalloc_pkg::ID_W-1:0]     out_result_id_r, rid_nxt;
  logic [idalloc_pkg::STATUS_W-1:0] out_status_r, status_nxt;

  logic                             in_xfer, finish;
  logic                             map_rd, map_we, map_wdata;
  logic [idalloc_pkg::ID_W-1:0]     map_waddr;
  logic [idalloc_pkg::ID_W-1:0]     q_id;
  logic [idalloc_pkg::TIME_W-1:0]   q_time;
  logic [idalloc_pkg::TIME_W-1:0]   age;
  logic [idalloc_pkg::CNT_W-1:0]    eff_limit;
  logic                             reuse, fresh_ok, is_alloc;
  idalloc_pkg::fifo_ctl_t           fctl;
  idalloc_pkg::fifo_sts_t           fsts;

  assign in_ready  = !busy_r;
  assign in_xfer   = in_valid && in_ready;
  assign finish    = busy_r && (!out_valid_r || out_ready);
  assign cfg_ready = 1'b1;

  // limit above capacity saturates
  assign eff_limit = (idalloc_pkg::CNT_W'(id_limit_r) > MAX_CNT) ? MAX_CNT
                   : idalloc_pkg::CNT_W'(id_limit_r);

  assign age      = now_r - q_time;
  assign reuse    = !fsts.empty && (age >= cooldown_r);
  assign fresh_ok = fresh_r < eff_limit;
  assign is_alloc = (idalloc_pkg::CNT_W'(id_r) < fresh_r) && map_rd;

  always_comb begin
    rid_nxt    = id_r;
    status_nxt = idalloc_pkg::ST_INVALID;
    fresh_nxt  = fresh_r;
    map_we     = 1'b0;
    map_waddr  = id_r;
    map_wdata  = 1'b0;
    fctl.rd_en = in_xfer;
    fctl.pop   = 1'b0;
    fctl.push  = 1'b0;
    unique case (op_r)
      idalloc_pkg::OP_ALLOC: begin
        map_wdata = 1'b1;
        if (reuse) begin
          rid_nxt    = q_id;
          status_nxt = idalloc_pkg::ST_OK;
          map_we     = finish;
          map_waddr  = q_id;
          fctl.pop   = finish;
        end else if (fresh_ok) begin
          rid_nxt    = fresh_r[idalloc_pkg::ID_W-1:0];
          status_nxt = idalloc_pkg::ST_OK;
          map_we     = finish;
          map_waddr  = fresh_r[idalloc_pkg::ID_W-1:0];
          if (finish) begin
            fresh_nxt = fresh_r + 1'b1;
          end
        end else begin
          status_nxt = idalloc_pkg::ST_NONE;
        end
      end
      idalloc_pkg::OP_RELEASE: begin
        if (is_alloc && !fsts.full) begin
          status_nxt = idalloc_pkg::ST_OK;
          map_we     = finish;
          fctl.push  = finish;
        end
      end
      idalloc_pkg::OP_CHECK: begin
        if (is_alloc) begin
          status_nxt = idalloc_pkg::ST_OK;
        end
      end
      default: begin
        status_nxt = idalloc_pkg::ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_limit_r  <= idalloc_pkg::LIMIT_RESET;
      cooldown_r  <= '0;
      fresh_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          idalloc_pkg::CFG_ID_LIMIT: id_limit_r <= cfg_data[idalloc_pkg::LIMIT_W-1:0];
          idalloc_pkg::CFG_COOLDOWN: cooldown_r <= cfg_data[idalloc_pkg::TIME_W-1:0];
          default: ;
        endcase
      end
      fresh_r <= fresh_nxt;
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (finish) begin
        busy_r <= 1'b0;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_op;
      id_r  <= in_id;
      now_r <= in_now;
    end
    if (finish) begin
      out_result_id_r <= rid_nxt;
      out_status_r    <= status_nxt;
    end
  end

  idalloc_ram #(
    .WIDTH (1),
    .DEPTH (idalloc_pkg::MAX_IDS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_xfer),
    .raddr (in_id),
    .rdata (map_rd)
  );

  idalloc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fctl),
    .push_id   (id_r),
    .push_time (now_r),
    .head_id   (q_id),
    .head_time (q_time),
    .sts       (fsts)
  );

  assign out_valid     = out_valid_r;
  assign out_result_id = out_result_id_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= MAX_CNT)
    else $error("fresh count above capacity");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (!out_valid_r || out_ready) |=> !busy_r)
    else $error("request did not retire");

  a_alloc_minted: assert property (@(posedge clk) disable iff (!rst_n)
    finish && op_r == idalloc_pkg::OP_ALLOC && status_nxt == idalloc_pkg::ST_OK
    |=> idalloc_pkg::CNT_W'(out_result_id) < fresh_r)
    else $error("allocated id was never minted");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fctl.pop |-> !fsts.empty && !fctl.push)
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

### sv/idalloc_ram.sv
// ----------------------------------------------------------------------------
// idalloc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/idalloc_fifo.sv
// ----------------------------------------------------------------------------
// idalloc_fifo
// Queue of released IDs with their release times, held in one RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idalloc_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire idalloc_pkg::fifo_ctl_t          ctl,
  input  wire logic [idalloc_pkg::ID_W-1:0]    push_id,
  input  wire logic [idalloc_pkg::TIME_W-1:0]  push_time,
  output logic      [idalloc_pkg::ID_W-1:0]    head_id,
  output logic      [idalloc_pkg::TIME_W-1:0]  head_time,
  output idalloc_pkg::fifo_sts_t               sts
);

  localparam int EW = idalloc_pkg::ID_W + idalloc_pkg::TIME_W;
  localparam logic [idalloc_pkg::ID_W-1:0] LAST =
    idalloc_pkg::ID_W'(idalloc_pkg::MAX_IDS - 1);

  logic [idalloc_pkg::ID_W-1:0]  head_r, head_nxt;
  logic [idalloc_pkg::ID_W-1:0]  tail_r, tail_nxt;
  logic [idalloc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [EW-1:0]                 rd_entry;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt  = (head_r == LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (ctl.push) begin
      tail_nxt  = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  idalloc_ram #(
    .WIDTH (EW),
    .DEPTH (idalloc_pkg::MAX_IDS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (tail_r),
    .wdata ({push_id, push_time}),
    .re    (ctl.rd_en),
    .raddr (head_r),
    .rdata (rd_entry)
  );

  assign head_id   = rd_entry[EW-1 -: idalloc_pkg::ID_W];
  assign head_time = rd_entry[idalloc_pkg::TIME_W-1:0];
  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == idalloc_pkg::CNT_W'(idalloc_pkg::MAX_IDS));

endmodule

`default_nettype wire

### bench/id_allocator_with_cooldown_tb.sv
// ----------------------------------------------------------------------------
// id_allocator_with_cooldown_tb
// Self-checking bench for the ID allocator with reuse delay. A queue-fed
// driver offers allocate, release and check requests, and a clocked monitor
// compares every result with a local model of the free list, the bitmap and
// the fresh counter. Configuration changes happen between phases, once the
// block has gone quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module id_allocator_with_cooldown_tb;
  import idalloc_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [TIME_W-1:0] TIME_TOP    = {TIME_W{1'b1}};
  localparam int                CYCLE_LIMIT = 400000;
  localparam int                PHASE_LEN   = 330;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] now;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]     rid;
    logic [STATUS_W-1:0] status;
  } answer_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } parked_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op     = '0;
  logic [ID_W-1:0]       in_id     = '0;
  logic [TIME_W-1:0]     in_now    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ID_W-1:0]       out_result_id;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // model of the allocator
  logic [LIMIT_W-1:0] lim_reg = LIMIT_RESET;
  logic [TIME_W-1:0]  cd_reg  = '0;
  bit                 taken [MAX_IDS];
  logic [CNT_W-1:0]   minted  = '0;
  parked_t            parked [$];

  request_t pending [$];
  answer_t  expected [$];

  // stimulus shaping
  int                gen_hi  = 0;
  int                gen_cap = MAX_IDS;
  logic [TIME_W-1:0] clock_now = '0;
  bit                quiet = 1'b0;
  bit                pressure_armed = 1'b0;
  bit                pressure_done = 1'b0;
  int                hold_left = 0;
  int                gap_left = 0;
  int                stall_left = 0;

  int errors = 0;
  int n_requests = 0;
  int n_checked = 0;
  int n_reused = 0;
  int n_exhausted = 0;
  int n_released = 0;
  int blocked_cycles = 0;
  int cycles = 0;

  id_allocator_with_cooldown u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_id         (in_id),
    .in_now        (in_now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_id (out_result_id),
    .out_status    (out_status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit is_held(input logic [ID_W-1:0] id);
    return ({1'b0, id} < minted) && taken[id];
  endfunction

  function automatic answer_t allocator_answer(input request_t rq);
    answer_t           a;
    parked_t           head;
    logic [TIME_W-1:0] age;
    logic [CNT_W-1:0]  cap;
    a.rid    = rq.id;
    a.status = ST_INVALID;
    cap = (lim_reg > MAX_IDS) ? CNT_W'(MAX_IDS) : CNT_W'(lim_reg);
    case (rq.op)
      OP_ALLOC: begin
        a.status = ST_NONE;
        if (parked.size() != 0) begin
          // time stamps wrap, so the age is taken modulo the counter width
          age = rq.now - parked[0].stamp;
          if (age >= cd_reg) begin
            head = parked.pop_front();
            taken[head.id] = 1'b1;
            a.rid    = head.id;
            a.status = ST_OK;
            n_reused++;
          end
        end
        if (a.status != ST_OK && minted < cap) begin
          taken[minted[ID_W-1:0]] = 1'b1;
          a.rid    = minted[ID_W-1:0];
          a.status = ST_OK;
          minted++;
        end
        if (a.status == ST_NONE) n_exhausted++;
      end
      OP_RELEASE: begin
        if (is_held(rq.id) && parked.size() < MAX_IDS) begin
          head.id    = rq.id;
          head.stamp = rq.now;
          parked.push_back(head);
          taken[rq.id] = 1'b0;
          a.status = ST_OK;
          n_released++;
        end
      end
      OP_CHECK: begin
        if (is_held(rq.id)) a.status = ST_OK;
      end
      default: ;
    endcase
    return a;
  endfunction

  // driver
  always @(posedge clk) begin
    request_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        item.op  = in_op;
        item.id  = in_id;
        item.now = in_now;
        expected.push_back(allocator_answer(item));
        n_requests++;
      end
      if (in_valid && !in_ready) begin
        // payload holds until the transfer
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap_left <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else begin
        item = pending.pop_front();
        in_valid <= 1'b1;
        in_op    <= item.op;
        in_id    <= item.id;
        in_now   <= item.now;
      end
    end
  end

  // long receiver hold-off, once, while plenty of requests are queued
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (in_valid && !in_ready) blocked_cycles++;
    end else if (pressure_armed && !pressure_done && pending.size() > 40) begin
      hold_left     <= 300;
      pressure_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    answer_t want;
    logic    ready_next;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          $display("%0t: result with nothing outstanding: id %0d status %0d",
                   $time, out_result_id, out_status);
          errors++;
        end else begin
          want = expected.pop_front();
          n_checked++;
          if (out_result_id !== want.rid) begin
            $display("%0t: result_id expected %0d, got %0d",
                     $time, want.rid, out_result_id);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, out_status);
            errors++;
          end
        end
      end
      ready_next = 1'b1;
      if (hold_left != 0) begin
        ready_next = 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        ready_next = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 3);
        ready_next = 1'b0;
      end
      out_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d requests queued, %0d results outstanding",
               $time, pending.size(), expected.size());
      $display("** id_allocator_with_cooldown: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ID_LIMIT) begin
      lim_reg = val[LIMIT_W-1:0];
      gen_cap = (lim_reg > MAX_IDS) ? MAX_IDS : int'(lim_reg);
    end else begin
      cd_reg = val[TIME_W-1:0];
    end
  endtask

  task automatic push_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] now);
    request_t rq;
    rq.op  = op;
    rq.id  = id;
    rq.now = now;
    pending.push_back(rq);
  endtask

  // look just after the edge, once the driver and monitor updates have landed
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_valid || expected.size() != 0);
  endtask

  // allocates, releases, checks and unused codes, the non-allocates mostly on IDs
  // likely in use, with time stepping in small increments and the odd large jump
  task automatic queue_requests(input int count);
    request_t rq;
    int       pick;
    int       span;
    for (int k = 0; k < count; k++) begin
      pick  = $urandom_range(0, 99);
      rq.id = ID_W'($urandom);
      if (pick < 45) begin
        rq.op = OP_ALLOC;
        if (gen_hi < gen_cap) gen_hi++;
      end else if (pick < 80) begin
        rq.op = OP_RELEASE;
      end else if (pick < 95) begin
        rq.op = OP_CHECK;
      end else begin
        rq.op = OP_UNUSED;
      end
      span = (gen_hi < MAX_IDS) ? gen_hi : MAX_IDS - 1;
      if (rq.op != OP_ALLOC && $urandom_range(0, 5) != 0)
        rq.id = ID_W'($urandom_range(0, span));
      pick = $urandom_range(0, 99);
      if (pick < 70)
        clock_now = clock_now + TIME_W'($urandom_range(0, 8));
      else if (pick < 90)
        clock_now = clock_now + TIME_W'($urandom_range(0, 200));
      else if (pick < 98)
        clock_now = clock_now + TIME_W'($urandom);
      else
        clock_now = TIME_W'({$urandom, $urandom});
      rq.now = clock_now;
      pending.push_back(rq);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] lim;
    logic [CFG_DATA_W-1:0] cd;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty allocator, reuse with no delay
    push_req(OP_CHECK,   10'd0,    48'd0);
    push_req(OP_RELEASE, 10'd1023, 48'd0);
    push_req(OP_UNUSED,  10'd1023, 48'd0);
    push_req(OP_ALLOC,   10'd1023, 48'd1);
    push_req(OP_ALLOC,   10'd0,    48'd1);
    push_req(OP_CHECK,   10'd0,    48'd2);
    push_req(OP_CHECK,   10'd1023, 48'd2);
    push_req(OP_RELEASE, 10'd0,    48'd5);
    push_req(OP_RELEASE, 10'd0,    48'd5);
    push_req(OP_ALLOC,   10'd7,    48'd5);
    push_req(OP_UNUSED,  10'd0,    48'd6);
    push_req(OP_CHECK,   10'd0,    48'd6);
    drain();

    // limit reached, reuse delay straddling the time wrap
    write_reg(CFG_ID_LIMIT, 48'd2);
    write_reg(CFG_COOLDOWN, 48'd100);
    push_req(OP_RELEASE, 10'd1,    TIME_TOP - 48'd9);
    push_req(OP_ALLOC,   10'd1023, TIME_TOP - 48'd4);
    push_req(OP_ALLOC,   10'd512,  48'd89);
    push_req(OP_ALLOC,   10'd0,    48'd90);
    push_req(OP_CHECK,   10'd1,    48'd90);
    drain();

    // no minting at all, largest reuse delay met exactly
    write_reg(CFG_ID_LIMIT, 48'd0);
    write_reg(CFG_COOLDOWN, CFG_DATA_W'(TIME_TOP));
    push_req(OP_RELEASE, 10'd0,    48'd1000);
    push_req(OP_ALLOC,   10'd0,    48'd999);
    push_req(OP_ALLOC,   10'd341,  48'd999);
    push_req(OP_CHECK,   10'd1023, 48'd999);
    drain();
    gen_hi = 2;

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lim = 48'd2047; cd = 48'd0; end
        1: begin lim = 48'd16;   cd = 48'd20; end
        2: begin lim = 48'd0;    cd = 48'd5; end
        3: begin lim = 48'd1024; cd = CFG_DATA_W'(TIME_TOP); end
        4: begin lim = 48'($urandom_range(0, 2047)); cd = 48'({$urandom, $urandom}); end
        default: begin lim = 48'd1025; cd = 48'($urandom_range(0, 300)); end
      endcase
      write_reg(CFG_ID_LIMIT, lim);
      write_reg(CFG_COOLDOWN, cd);
      if (p[0])
        clock_now = TIME_W'({$urandom, $urandom});
      else
        clock_now = TIME_TOP - TIME_W'($urandom_range(0, 400));
      pressure_armed = (p == 3);
      quiet = (p == 5);
      queue_requests(PHASE_LEN);
      drain();
    end
    pressure_armed = 1'b0;

    repeat (6) @(posedge clk);
    if (expected.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected.size());
      errors++;
    end
    $display("requests %0d, results checked %0d: %0d reuses, %0d exhausted, %0d releases",
             n_requests, n_checked, n_reused, n_exhausted, n_released);
    $display("output held off long enough to block the input for %0d cycles, %0d mismatches",
             blocked_cycles, errors);
    if (errors == 0) begin
      $display("** id_allocator_with_cooldown: PASSED **");
    end else begin
      $display("** id_allocator_with_cooldown: FAILED **");
    end
    $finish;
  end

endmodule
